/* hw/rtl/bfc_pkg.sv */
// ----------------------------------------------------------------------------
// Box frustum classifier package
// Shared types and constants: plane register layout, register indexes,
// verdict codes and the per-corner tag that travels through the queue.
// ----------------------------------------------------------------------------
package bfc_pkg;

	localparam int REG_PLANES   = 6;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 64;
	localparam int NORMAL_W     = 16;
	localparam int OFFSET_SHIFT = 14;
	localparam int QUEUE_DEPTH  = 4;

	// Plane register: normal x in bits 15:0 up to the offset in bits 63:48.
	typedef struct packed {
		logic signed [NORMAL_W-1:0] off;
		logic signed [NORMAL_W-1:0] nz;
		logic signed [NORMAL_W-1:0] ny;
		logic signed [NORMAL_W-1:0] nx;
	} plane_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PLANE_NEAR   = 3'd0,
		REG_PLANE_FAR    = 3'd1,
		REG_PLANE_LEFT   = 3'd2,
		REG_PLANE_RIGHT  = 3'd3,
		REG_PLANE_BOTTOM = 3'd4,
		REG_PLANE_TOP    = 3'd5,
		REG_FRUSTUM_OK   = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		VERDICT_INSIDE    = 2'd0,
		VERDICT_INTERSECT = 2'd1,
		VERDICT_OUTSIDE   = 2'd2
	} verdict_t;

	// Position of a corner within its box, and its presence flag.
	typedef struct packed {
		logic first;
		logic last;
		logic present;
	} corner_tag_t;

	localparam int TAG_W = $bits(corner_tag_t);

endpackage

/* hw/rtl/bfc_front.sv */
// ----------------------------------------------------------------------------
// Box frustum classifier front end
// Accepts corners, tags them with their place in the box and forms the
// signed plane distances in two stages before pushing them into the queue.
// ----------------------------------------------------------------------------
module bfc_front #(
	parameter int PLANE_COUNT  = 6,
	parameter int CORNER_COUNT = 8,
	parameter int COORD_BITS   = 16,
	parameter int DIST_W       = 34,
	parameter int QCOUNT_W     = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 corner_valid,
	output logic                                 corner_stall,
	input  logic signed [COORD_BITS-1:0]         corner_x,
	input  logic signed [COORD_BITS-1:0]         corner_y,
	input  logic signed [COORD_BITS-1:0]         corner_z,
	input  logic                                 box_present,
	input  bfc_pkg::plane_t                      planes [PLANE_COUNT],
	input  logic [QCOUNT_W-1:0]                  queue_count,
	output logic                                 push,
	output logic [PLANE_COUNT*DIST_W+bfc_pkg::TAG_W-1:0] push_data
);
	import bfc_pkg::*;

	localparam int PROD_W = NORMAL_W + COORD_BITS;
	localparam int IDX_W  = (CORNER_COUNT > 1) ? $clog2(CORNER_COUNT) : 1;
	localparam int OCC_W  = QCOUNT_W + 1;

	logic                         accept;
	logic                         last_corner;
	logic [IDX_W-1:0]             corner_idx_q;
	logic [OCC_W-1:0]             occupancy;

	logic                         valid_s1;
	corner_tag_t                  tag_s1;
	logic signed [PROD_W-1:0]     prod_x_s1 [PLANE_COUNT];
	logic signed [PROD_W-1:0]     prod_y_s1 [PLANE_COUNT];
	logic signed [PROD_W-1:0]     prod_z_s1 [PLANE_COUNT];

	logic                         valid_s2;
	corner_tag_t                  tag_s2;
	logic [PLANE_COUNT*DIST_W-1:0] dist_s2;

	// Items in the pipe count against the queue so that nothing is lost.
	assign occupancy = OCC_W'(queue_count) + OCC_W'(valid_s1) + OCC_W'(valid_s2);
	assign corner_stall = (occupancy >= OCC_W'(QUEUE_DEPTH));
	assign accept = corner_valid && !corner_stall;
	assign last_corner = (corner_idx_q == IDX_W'(CORNER_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_idx_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (accept) begin
				corner_idx_q <= last_corner ? '0 : corner_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1.first <= (corner_idx_q == '0);
			tag_s1.last <= last_corner;
			tag_s1.present <= box_present;
			for (int p = 0; p < PLANE_COUNT; p++) begin
				prod_x_s1[p] <= planes[p].nx * corner_x;
				prod_y_s1[p] <= planes[p].ny * corner_y;
				prod_z_s1[p] <= planes[p].nz * corner_z;
			end
		end
		if (valid_s1) begin
			tag_s2 <= tag_s1;
			for (int p = 0; p < PLANE_COUNT; p++) begin
				dist_s2[p*DIST_W +: DIST_W] <=
					{{(DIST_W-PROD_W){prod_x_s1[p][PROD_W-1]}}, prod_x_s1[p]} +
					{{(DIST_W-PROD_W){prod_y_s1[p][PROD_W-1]}}, prod_y_s1[p]} +
					{{(DIST_W-PROD_W){prod_z_s1[p][PROD_W-1]}}, prod_z_s1[p]} +
					{{(DIST_W-NORMAL_W-OFFSET_SHIFT){planes[p].off[NORMAL_W-1]}},
						planes[p].off, {OFFSET_SHIFT{1'b0}}};
			end
		end
	end

	assign push = valid_s2;
	assign push_data = {tag_s2, dist_s2};

endmodule

/* hw/rtl/bfc_queue.sv */
// ----------------------------------------------------------------------------
// Box frustum classifier queue
// Short first-in first-out buffer between the distance front end and the
// verdict back end. The front end never pushes into a full queue.
// ----------------------------------------------------------------------------
module bfc_queue #(
	parameter int DATA_W   = 8,
	parameter int QCOUNT_W = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [DATA_W-1:0]   push_data,
	input  logic                pop,
	output logic                not_empty,
	output logic [DATA_W-1:0]   pop_data,
	output logic [QCOUNT_W-1:0] count
);
	import bfc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [DATA_W-1:0]   entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCOUNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCOUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count = count_q;

endmodule

/* hw/rtl/bfc_back.sv */
// ----------------------------------------------------------------------------
// Box frustum classifier back end
// Keeps the running minimum and maximum distance per plane over the corners
// of a box and holds the verdict in an output register until it is taken.
// ----------------------------------------------------------------------------
module bfc_back #(
	parameter int PLANE_COUNT = 6,
	parameter int DIST_W      = 34
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 entry_valid,
	input  logic [PLANE_COUNT*DIST_W+bfc_pkg::TAG_W-1:0] entry_data,
	output logic                                 pop,
	input  logic                                 frustum_ok,
	output logic                                 verdict_valid,
	input  logic                                 verdict_stall,
	output logic [1:0]                           verdict
);
	import bfc_pkg::*;

	localparam int DATA_W = PLANE_COUNT * DIST_W + TAG_W;

	corner_tag_t              tag;
	logic signed [DIST_W-1:0] dist_in  [PLANE_COUNT];
	logic signed [DIST_W-1:0] min_next [PLANE_COUNT];
	logic signed [DIST_W-1:0] max_next [PLANE_COUNT];
	logic signed [DIST_W-1:0] plane_min_q [PLANE_COUNT];
	logic signed [DIST_W-1:0] plane_max_q [PLANE_COUNT];
	logic                     any_min_neg;
	logic                     any_max_neg;
	logic                     missing_now;
	logic                     box_missing_q;
	logic                     valid_q;
	verdict_t                 verdict_next;
	verdict_t                 verdict_q;

	assign tag = corner_tag_t'(entry_data[DATA_W-1 -: TAG_W]);

	always_comb begin
		any_min_neg = 1'b0;
		any_max_neg = 1'b0;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			dist_in[p] = $signed(entry_data[p*DIST_W +: DIST_W]);
			min_next[p] = (tag.first || dist_in[p] < plane_min_q[p]) ?
				dist_in[p] : plane_min_q[p];
			max_next[p] = (tag.first || dist_in[p] > plane_max_q[p]) ?
				dist_in[p] : plane_max_q[p];
			any_min_neg = any_min_neg | min_next[p][DIST_W-1];
			any_max_neg = any_max_neg | max_next[p][DIST_W-1];
		end
	end

	assign missing_now = box_missing_q || !tag.present;

	always_comb begin
		priority if (!frustum_ok || missing_now || any_max_neg) begin
			verdict_next = VERDICT_OUTSIDE;
		end else if (any_min_neg) begin
			verdict_next = VERDICT_INTERSECT;
		end else begin
			verdict_next = VERDICT_INSIDE;
		end
	end

	// A last corner waits only while the output register holds an untaken verdict.
	assign pop = entry_valid && (!tag.last || !valid_q || !verdict_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_missing_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				box_missing_q <= tag.last ? 1'b0 : missing_now;
			end
			if (pop && tag.last) begin
				valid_q <= 1'b1;
			end else if (!verdict_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				plane_min_q[p] <= min_next[p];
				plane_max_q[p] <= max_next[p];
			end
			if (tag.last) begin
				verdict_q <= verdict_next;
			end
		end
	end

	assign verdict_valid = valid_q;
	assign verdict = verdict_q;

endmodule

/* hw/rtl/box_frustum_classifier_unit.sv */
// ----------------------------------------------------------------------------
// Box frustum classifier
// Classifies a bounding box, given as a stream of its corners, against the
// clipping planes of a view frustum: inside, intersecting or outside.
// ----------------------------------------------------------------------------
// Usage. Corners arrive on the corner channel (corner_valid, corner_stall),
// CORNER_COUNT transfers to a box, each with its box_present flag. After the
// last corner of a box one verdict leaves on the verdict channel
// (verdict_valid, verdict_stall); the other corners give no result.
// Planes and the frustum_ok flag are written through the cfg_* port; the
// user must write them only while the block is idle, which the block itself
// does not enforce. A write to an index beyond the register list is ignored.
// Throughput is one corner per cycle while corner_stall is low, set by the
// per-plane multiply stage and the single min/max update in the back end.
// The verdict passes from the last corner through the product registers,
// the distance sum registers, a queue entry and the min/max update into
// the output register. When the receiver stalls, the verdict register holds
// its value and the queue of four entries keeps filling; once queue plus
// pipe reach four items corner_stall rises. Reset clears the configuration
// registers, the corner count, the queue and the output valid; the min/max
// store is written by the first corner of every box and needs no clearing.
// ----------------------------------------------------------------------------
module box_frustum_classifier_unit #(
	parameter int PLANE_COUNT  = 6,
	parameter int CORNER_COUNT = 8,
	parameter int COORD_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [bfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bfc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                corner_valid,
	output logic                                corner_stall,
	input  logic signed [COORD_BITS-1:0]        corner_x,
	input  logic signed [COORD_BITS-1:0]        corner_y,
	input  logic signed [COORD_BITS-1:0]        corner_z,
	input  logic                                box_present,
	output logic                                verdict_valid,
	input  logic                                verdict_stall,
	output logic [1:0]                          verdict
);
	import bfc_pkg::*;

	// Products are NORMAL_W + COORD_BITS wide; the scaled offset needs 30
	// bits. Two more bits hold the sum of four such terms exactly.
	localparam int PROD_W   = NORMAL_W + COORD_BITS;
	localparam int DIST_W   = ((PROD_W > NORMAL_W + OFFSET_SHIFT) ?
		PROD_W : NORMAL_W + OFFSET_SHIFT) + 2;
	localparam int DATA_W   = PLANE_COUNT * DIST_W + TAG_W;
	localparam int QCOUNT_W = $clog2(QUEUE_DEPTH + 1);

	plane_t                plane_q [REG_PLANES];
	plane_t                plane_sel [PLANE_COUNT];
	logic                  frustum_ok_q;

	logic                  push;
	logic [DATA_W-1:0]     push_data;
	logic                  pop;
	logic                  not_empty;
	logic [DATA_W-1:0]     pop_data;
	logic [QCOUNT_W-1:0]   queue_count;

	// Configuration registers. Only the register's own bits are kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_PLANES; i++) begin
				plane_q[i] <= '0;
			end
			frustum_ok_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PLANE_NEAR:   plane_q[0] <= plane_t'(cfg_data);
				REG_PLANE_FAR:    plane_q[1] <= plane_t'(cfg_data);
				REG_PLANE_LEFT:   plane_q[2] <= plane_t'(cfg_data);
				REG_PLANE_RIGHT:  plane_q[3] <= plane_t'(cfg_data);
				REG_PLANE_BOTTOM: plane_q[4] <= plane_t'(cfg_data);
				REG_PLANE_TOP:    plane_q[5] <= plane_t'(cfg_data);
				REG_FRUSTUM_OK:   frustum_ok_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Planes beyond the register set have no register: they read as zero,
	// give a distance of zero and so never change the verdict.
	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
		if (p < REG_PLANES) begin : g_reg
			assign plane_sel[p] = plane_q[p];
		end else begin : g_zero
			assign plane_sel[p] = '0;
		end
	end

	bfc_front #(
		.PLANE_COUNT  (PLANE_COUNT),
		.CORNER_COUNT (CORNER_COUNT),
		.COORD_BITS   (COORD_BITS),
		.DIST_W       (DIST_W),
		.QCOUNT_W     (QCOUNT_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.corner_valid (corner_valid),
		.corner_stall (corner_stall),
		.corner_x     (corner_x),
		.corner_y     (corner_y),
		.corner_z     (corner_z),
		.box_present  (box_present),
		.planes       (plane_sel),
		.queue_count  (queue_count),
		.push         (push),
		.push_data    (push_data)
	);

	bfc_queue #(
		.DATA_W   (DATA_W),
		.QCOUNT_W (QCOUNT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data),
		.count     (queue_count)
	);

	bfc_back #(
		.PLANE_COUNT (PLANE_COUNT),
		.DIST_W      (DIST_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.entry_valid   (not_empty),
		.entry_data    (pop_data),
		.pop           (pop),
		.frustum_ok    (frustum_ok_q),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.verdict       (verdict)
	);

endmodule

/* hw/rtl/bfc_checker.sv */
// ----------------------------------------------------------------------------
// Box frustum classifier port checker
// Watches the top-level channels for reset behaviour, held verdicts and
// the draining of the internal queue when both sides are quiet.
// ----------------------------------------------------------------------------
module bfc_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       corner_valid,
	input  logic       corner_stall,
	input  logic       verdict_valid,
	input  logic       verdict_stall,
	input  logic [1:0] verdict
);

	// While reset is held nothing is offered and corners are not refused.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> (!verdict_valid && !corner_stall))
	else $error("outputs active during reset");

	// A stalled verdict stays offered and unchanged.
	a_verdict_held: assert property (@(posedge clk) disable iff (!arst_n)
		(verdict_valid && verdict_stall) |=> (verdict_valid && $stable(verdict)))
	else $error("stalled verdict dropped or changed");

	// With no corners arriving and no verdict pending, the pipe and queue
	// drain and the corner channel opens again.
	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(!corner_valid && !verdict_valid) ##1 (!corner_valid && !verdict_valid) ##1
		(!corner_valid && !verdict_valid) ##1 (!corner_valid && !verdict_valid) ##1
		(!corner_valid && !verdict_valid) ##1 (!corner_valid && !verdict_valid)
		|=> !corner_stall)
	else $error("corner channel still stalled after the queue should have drained");

endmodule

bind box_frustum_classifier_unit bfc_checker u_bfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.corner_valid  (corner_valid),
	.corner_stall  (corner_stall),
	.verdict_valid (verdict_valid),
	.verdict_stall (verdict_stall),
	.verdict       (verdict)
);
